[sv/sha_pkg.sv]
// sha-256 package: round constants, initial hash values and shared types
// no dependencies
`default_nettype none
package sha_pkg;

    localparam int unsigned WORDS = 8;
    localparam int unsigned BLOCK_WORDS = 16;
    localparam logic [5:0] PAD_LIMIT = 6'd56;
    localparam logic [7:0] PAD_BYTE = 8'h80;

    typedef logic [31:0] word_t;

    // one queued command from front to back
    typedef struct packed {
        logic       compress;
        logic       finish;
    } cmd_t;

    function automatic word_t round_k(input logic [5:0] i);
        word_t k;
        case (i)
            6'd0: k = 32'h428a2f98; 6'd1: k = 32'h71374491; 6'd2: k = 32'hb5c0fbcf;
            6'd3: k = 32'he9b5dba5; 6'd4: k = 32'h3956c25b; 6'd5: k = 32'h59f111f1;
            6'd6: k = 32'h923f82a4; 6'd7: k = 32'hab1c5ed5; 6'd8: k = 32'hd807aa98;
            6'd9: k = 32'h12835b01; 6'd10: k = 32'h243185be; 6'd11: k = 32'h550c7dc3;
            6'd12: k = 32'h72be5d74; 6'd13: k = 32'h80deb1fe; 6'd14: k = 32'h9bdc06a7;
            6'd15: k = 32'hc19bf174; 6'd16: k = 32'he49b69c1; 6'd17: k = 32'hefbe4786;
            6'd18: k = 32'h0fc19dc6; 6'd19: k = 32'h240ca1cc; 6'd20: k = 32'h2de92c6f;
            6'd21: k = 32'h4a7484aa; 6'd22: k = 32'h5cb0a9dc; 6'd23: k = 32'h76f988da;
            6'd24: k = 32'h983e5152; 6'd25: k = 32'ha831c66d; 6'd26: k = 32'hb00327c8;
            6'd27: k = 32'hbf597fc7; 6'd28: k = 32'hc6e00bf3; 6'd29: k = 32'hd5a79147;
            6'd30: k = 32'h06ca6351; 6'd31: k = 32'h14292967; 6'd32: k = 32'h27b70a85;
            6'd33: k = 32'h2e1b2138; 6'd34: k = 32'h4d2c6dfc; 6'd35: k = 32'h53380d13;
            6'd36: k = 32'h650a7354; 6'd37: k = 32'h766a0abb; 6'd38: k = 32'h81c2c92e;
            6'd39: k = 32'h92722c85; 6'd40: k = 32'ha2bfe8a1; 6'd41: k = 32'ha81a664b;
            6'd42: k = 32'hc24b8b70; 6'd43: k = 32'hc76c51a3; 6'd44: k = 32'hd192e819;
            6'd45: k = 32'hd6990624; 6'd46: k = 32'hf40e3585; 6'd47: k = 32'h106aa070;
            6'd48: k = 32'h19a4c116; 6'd49: k = 32'h1e376c08; 6'd50: k = 32'h2748774c;
            6'd51: k = 32'h34b0bcb5; 6'd52: k = 32'h391c0cb3; 6'd53: k = 32'h4ed8aa4a;
            6'd54: k = 32'h5b9cca4f; 6'd55: k = 32'h682e6ff3; 6'd56: k = 32'h748f82ee;
            6'd57: k = 32'h78a5636f; 6'd58: k = 32'h84c87814; 6'd59: k = 32'h8cc70208;
            6'd60: k = 32'h90befffa; 6'd61: k = 32'ha4506ceb; 6'd62: k = 32'hbef9a3f7;
            default: k = 32'hc67178f2;
        endcase
        return k;
    endfunction

    function automatic word_t init_h(input logic [2:0] i);
        word_t h;
        case (i)
            3'd0: h = 32'h6a09e667; 3'd1: h = 32'hbb67ae85;
            3'd2: h = 32'h3c6ef372; 3'd3: h = 32'ha54ff53a;
            3'd4: h = 32'h510e527f; 3'd5: h = 32'h9b05688c;
            3'd6: h = 32'h1f83d9ab;
            default: h = 32'h5be0cd19;
        endcase
        return h;
    endfunction

endpackage
`default_nettype wire

[sv/sha_if.sv]
// valid/ready channel interfaces for the byte input and the digest output
// depends on nothing
`default_nettype none
interface sha_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
    modport source (output valid, data_byte, has_byte, end_of_message, input ready);
    modport sink (input valid, data_byte, has_byte, end_of_message, output ready);
endinterface

interface sha_out_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink (input valid, digest_word, word_index, last_word, output ready);
endinterface
`default_nettype wire

[sv/sha256_message_digest.sv]
// Streaming SHA-256: one byte transfer per cycle while the front end collects a block;
// each 64-byte block then passes through the back end, a load step and 64 rounds,
// and a one-block queue lets the next block fill meanwhile; byte transfers stall while
// that queue is full. After the end-of-message transfer the front end pads in two
// steps, F_PAD then F_LEN, each held while the queue is full; then up to two
// compressions run and eight digest word transfers follow, word 0 first. No byte
// transfer is taken from end of message until the length block is queued.
`default_nettype none
module sha256_message_digest (
    input wire logic  clk,
    input wire logic  rst_n,
    sha_in_if.sink    in_ch,
    sha_out_if.source out_ch
);
    sha_pkg::cmd_t cmd;
    logic          cmd_valid;
    logic          cmd_ready;
    logic [511:0]  blk;

    sha_front u_front (
        .clk(clk), .rst_n(rst_n), .in_ch(in_ch),
        .cmd(cmd), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .blk(blk)
    );

    sha_back u_back (
        .clk(clk), .rst_n(rst_n),
        .cmd(cmd), .cmd_valid(cmd_valid), .cmd_ready(cmd_ready), .blk(blk),
        .out_ch(out_ch)
    );
endmodule
`default_nettype wire

[sv/sha_front.sv]
// front end: packs bytes into block words, counts bits, inserts padding
// hands full blocks to the back end through a one-entry block queue; uses sha_pkg
`default_nettype none
module sha_front (
    input  wire logic clk,
    input  wire logic rst_n,
    sha_in_if.sink    in_ch,
    output sha_pkg::cmd_t cmd,
    output logic      cmd_valid,
    input  wire logic cmd_ready,
    output logic [511:0] blk
);
    typedef enum logic [2:0] {
        F_TAKE = 3'b001,
        F_PAD  = 3'b010,
        F_LEN  = 3'b100
    } fstate_t;

    fstate_t      state_reg, state_next;
    logic [511:0] buf_reg, buf_next;
    logic [63:0]  count_reg, count_next;
    logic [5:0]   pos_reg, pos_next;
    logic         q_valid_reg, q_valid_next;
    sha_pkg::cmd_t q_cmd_reg, q_cmd_next;
    logic [511:0] q_blk_reg, q_blk_next;

    logic         q_free;
    logic [8:0]   bit_lo;

    assign q_free = !q_valid_reg || cmd_ready;
    assign in_ch.ready = (state_reg == F_TAKE) && q_free;
    assign cmd_valid = q_valid_reg;
    assign cmd = q_cmd_reg;
    assign blk = q_blk_reg;
    assign bit_lo = {3'b000, ~pos_reg} << 3;

    always_comb
    begin
        state_next = state_reg;
        buf_next = buf_reg;
        count_next = count_reg;
        pos_next = pos_reg;
        q_valid_next = q_valid_reg && !cmd_ready;
        q_cmd_next = q_cmd_reg;
        q_blk_next = q_blk_reg;
        case (state_reg)
            F_TAKE:
            begin
                if (in_ch.valid && q_free)
                begin
                    if (in_ch.has_byte)
                    begin
                        buf_next[bit_lo[8:0] +: 8] = in_ch.data_byte;
                        count_next = count_reg + 64'd8;
                        pos_next = pos_reg + 6'd1;
                        if (pos_reg == 6'd63)
                        begin
                            q_valid_next = 1'b1;
                            q_cmd_next = '{compress: 1'b1, finish: 1'b0};
                            q_blk_next = buf_next;
                        end
                    end
                    if (in_ch.end_of_message)
                    begin
                        state_next = F_PAD;
                    end
                end
            end
            F_PAD:
            begin
                // place 0x80 and zero the rest of the block in one step
                if (q_free)
                begin
                    for (int i = 0; i < 64; i++)
                    begin
                        if (6'(i) == pos_reg)
                            buf_next[(63 - i) * 8 +: 8] = sha_pkg::PAD_BYTE;
                        else if (6'(i) > pos_reg)
                            buf_next[(63 - i) * 8 +: 8] = 8'h00;
                    end
                    if (pos_reg >= sha_pkg::PAD_LIMIT)
                    begin
                        q_valid_next = 1'b1;
                        q_cmd_next = '{compress: 1'b1, finish: 1'b0};
                        q_blk_next = buf_next;
                        buf_next = '0;
                    end
                    state_next = F_LEN;
                end
            end
            F_LEN:
            begin
                if (q_free)
                begin
                    q_valid_next = 1'b1;
                    q_cmd_next = '{compress: 1'b1, finish: 1'b1};
                    q_blk_next = {buf_reg[511:64], count_reg};
                    count_next = '0;
                    pos_next = '0;
                    state_next = F_TAKE;
                end
            end
            default:
            begin
                state_next = F_TAKE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= F_TAKE;
            count_reg <= '0;
            pos_reg <= '0;
            q_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pos_reg <= pos_next;
            q_valid_reg <= q_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        buf_reg <= buf_next;
        q_cmd_reg <= q_cmd_next;
        q_blk_reg <= q_blk_next;
    end
endmodule
`default_nettype wire

[sv/sha_back.sv]
// back end: 64-round compression, one round per cycle, and digest output
// takes blocks from the front end; uses sha_pkg
`default_nettype none
module sha_back (
    input  wire logic clk,
    input  wire logic rst_n,
    input  sha_pkg::cmd_t cmd,
    input  wire logic cmd_valid,
    output logic      cmd_ready,
    input  wire logic [511:0] blk,
    sha_out_if.source out_ch
);
    typedef enum logic [2:0] {
        B_IDLE  = 3'b001,
        B_ROUND = 3'b010,
        B_OUT   = 3'b100
    } bstate_t;

    bstate_t      state_reg, state_next;
    logic [255:0] h_reg, h_next;
    logic [255:0] v_reg, v_next;
    logic [511:0] w_reg, w_next;
    logic [5:0]   rnd_reg, rnd_next;
    logic         fin_reg, fin_next;
    logic [2:0]   idx_reg, idx_next;

    sha_pkg::word_t a, b, c, d, e, f, g, h, w0, w1, w9, w14, t1, t2, s0, s1, q0, q1, wn;

    assign {a, b, c, d, e, f, g, h} = v_reg;
    assign w0 = w_reg[511:480];
    assign w1 = w_reg[479:448];
    assign w9 = w_reg[223:192];
    assign w14 = w_reg[63:32];
    assign q0 = {w1[6:0], w1[31:7]} ^ {w1[17:0], w1[31:18]} ^ (w1 >> 3);
    assign q1 = {w14[16:0], w14[31:17]} ^ {w14[18:0], w14[31:19]} ^ (w14 >> 10);
    assign wn = w0 + q0 + w9 + q1;
    assign s1 = {e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]};
    assign s0 = {a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]};
    assign t1 = h + s1 + ((e & f) ^ (~e & g)) + sha_pkg::round_k(rnd_reg) + w0;
    assign t2 = s0 + ((a & b) ^ (a & c) ^ (b & c));

    assign cmd_ready = (state_reg == B_IDLE);
    assign out_ch.valid = (state_reg == B_OUT);
    assign out_ch.digest_word = h_reg[255:224];
    assign out_ch.word_index = idx_reg;
    assign out_ch.last_word = (idx_reg == 3'd7);

    always_comb
    begin
        state_next = state_reg;
        h_next = h_reg;
        v_next = v_reg;
        w_next = w_reg;
        rnd_next = rnd_reg;
        fin_next = fin_reg;
        idx_next = idx_reg;
        case (state_reg)
            B_IDLE:
            begin
                if (cmd_valid)
                begin
                    v_next = h_reg;
                    w_next = blk;
                    rnd_next = '0;
                    fin_next = cmd.finish;
                    state_next = B_ROUND;
                end
            end
            B_ROUND:
            begin
                v_next = {t1 + t2, a, b, c, d + t1, e, f, g};
                w_next = {w_reg[479:0], wn};
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == 6'd63)
                begin
                    for (int i = 0; i < 8; i++)
                        h_next[i * 32 +: 32] = h_reg[i * 32 +: 32] + v_next[i * 32 +: 32];
                    idx_next = '0;
                    state_next = fin_reg ? B_OUT : B_IDLE;
                end
            end
            B_OUT:
            begin
                if (out_ch.ready)
                begin
                    h_next = {h_reg[223:0], 32'h0};
                    idx_next = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        for (int i = 0; i < 8; i++)
                            h_next[(7 - i) * 32 +: 32] = sha_pkg::init_h(3'(i));
                        state_next = B_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = B_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= B_IDLE;
            for (int i = 0; i < 8; i++)
                h_reg[(7 - i) * 32 +: 32] <= sha_pkg::init_h(3'(i));
            idx_reg <= '0;
            fin_reg <= 1'b0;
            rnd_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            h_reg <= h_next;
            idx_reg <= idx_next;
            fin_reg <= fin_next;
            rnd_reg <= rnd_next;
        end
    end

    always_ff @(posedge clk)
    begin
        v_reg <= v_next;
        w_reg <= w_next;
    end
endmodule
`default_nettype wire

[sv/sha_checker.sv]
// port-level checks for sha256_message_digest
// attached by bind below
`default_nettype none
module sha_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [2:0]  word_index,
    input wire logic        last_word
);
    a_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (last_word == (word_index == 3'd7)))
        else $error("last_word mismatch");
    a_step: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !last_word) |=> (out_valid && word_index == $past(word_index) + 3'd1))
        else $error("digest words not consecutive");
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(word_index)))
        else $error("stalled word changed");
endmodule

bind sha256_message_digest sha_checker u_chk (
    .clk(clk), .rst_n(rst_n), .out_valid(out_ch.valid), .out_ready(out_ch.ready),
    .word_index(out_ch.word_index), .last_word(out_ch.last_word)
);
`default_nettype wire

[verif/testbench.sv]
// sha-256 byte-stream digest testbench: directed messages, then random messages
// depends on sha_pkg (sv/sha_pkg.sv) and the channel interfaces (sv/sha_if.sv)
`timescale 1ns / 1ps
module testbench;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    sha_in_if in_ch ();
    sha_out_if out_ch ();

    sha256_message_digest dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

    always #10 clk = ~clk;

    logic [31:0] chain [8];
    logic [31:0] block [16];
    logic [63:0] bit_count;
    logic [5:0]  fill;
    digest_t     expected_words [$];
    int          mismatches = 0;
    int          send_idle = 0;
    int          recv_stall = 0;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
        32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
        32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
        32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
        32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
        32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
        32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
        32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
        32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

    localparam logic [31:0] START_H [8] = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372,
        32'ha54ff53a, 32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

    function automatic logic [31:0] rotr(logic [31:0] x, int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic restart_message();
        for (int i = 0; i < 8; i++) chain[i] = START_H[i];
        bit_count = '0;
        fill = '0;
    endtask

    task automatic store_byte(logic [5:0] pos, logic [7:0] b);
        block[pos[5:2]][31 - 8 * pos[1:0] -: 8] = b;
    endtask

    task automatic compress_block();
        logic [31:0] w [16];
        logic [31:0] v [8];
        logic [31:0] wt, t1, t2, x, y;
        for (int i = 0; i < 16; i++) w[i] = block[i];
        for (int i = 0; i < 8; i++) v[i] = chain[i];
        for (int i = 0; i < 64; i++)
        begin
            if (i < 16)
                wt = w[i];
            else
            begin
                x = w[(i - 15) & 15];
                y = w[(i - 2) & 15];
                wt = w[i & 15] + (rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3)) + w[(i - 7) & 15]
                    + (rotr(y, 17) ^ rotr(y, 19) ^ (y >> 10));
                w[i & 15] = wt;
            end
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
                + ((v[4] & v[5]) ^ (~v[4] & v[6])) + ROUND_K[i] + wt;
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
                + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            for (int j = 7; j > 0; j--) v[j] = v[j - 1];
            v[4] = v[4] + t1;
            v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
    endtask

    task automatic predict_digest(logic [7:0] b, logic has, logic eom);
        digest_t d;
        if (has)
        begin
            store_byte(fill, b);
            bit_count = bit_count + 64'd8;
            fill = fill + 6'd1;
            if (fill == 6'd0) compress_block();
        end
        if (!eom) return;
        store_byte(fill, sha_pkg::PAD_BYTE);
        fill = fill + 6'd1;
        if (fill > sha_pkg::PAD_LIMIT || fill == 6'd0)
        begin
            while (fill != 6'd0)
            begin
                store_byte(fill, 8'h00);
                fill = fill + 6'd1;
            end
            compress_block();
        end
        while (fill < sha_pkg::PAD_LIMIT)
        begin
            store_byte(fill, 8'h00);
            fill = fill + 6'd1;
        end
        block[14] = bit_count[63:32];
        block[15] = bit_count[31:0];
        compress_block();
        for (int i = 0; i < 8; i++)
        begin
            d.digest_word = chain[i];
            d.word_index = 3'(i);
            d.last_word = (i == 7);
            expected_words.insert(expected_words.size(), d);
        end
        restart_message();
    endtask

    initial
    begin
        in_ch.valid = 1'b0;
        in_ch.data_byte = '0;
        in_ch.has_byte = 1'b0;
        in_ch.end_of_message = 1'b0;
        out_ch.ready = 1'b0;
    end

    task automatic send_item(logic [7:0] b, logic has, logic eom);
        while (send_idle > 0 && $urandom_range(99) < send_idle)
        begin
            in_ch.valid <= 1'b0;
            @(posedge clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.data_byte <= b;
        in_ch.has_byte <= has;
        in_ch.end_of_message <= eom;
        do @(posedge clk); while (!in_ch.ready);
        predict_digest(b, has, eom);
    endtask

    task automatic send_message(int len, logic trailing_empty);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(15) == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
            send_item(8'($urandom_range(255)), 1'b1, !trailing_empty && i == len - 1);
        end
        if (trailing_empty || len == 0) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
    endtask

    always @(posedge clk)
    begin
        if (rst_n)
            out_ch.ready <= !(recv_stall > 0 && $urandom_range(99) < recv_stall);
    end

    always @(posedge clk)
    begin
        digest_t got, want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            got = '{out_ch.digest_word, out_ch.word_index, out_ch.last_word};
            if (expected_words.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected transfer %h", got);
            end
            else
            begin
                want = expected_words.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %h/%0d/%b, got %h/%0d/%b",
                            want.digest_word, want.word_index, want.last_word,
                            got.digest_word, got.word_index, got.last_word);
                end
            end
        end
    end

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0) @(posedge clk);
    endtask

    task automatic test_directed();
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h00, 1'b0, 1'b0);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_message(55, 1'b0);
        send_message(56, 1'b0);
        send_message(63, 1'b1);
        send_message(64, 1'b0);
        wait_drained();
    endtask

    task automatic test_random(int items);
        int sent;
        int len;
        sent = 0;
        while (sent < items)
        begin
            case ($urandom_range(3))
                0: len = $urandom_range(8);
                1: len = 52 + $urandom_range(14);
                default: len = $urandom_range(40);
            endcase
            send_message(len, $urandom_range(3) == 0);
            sent += len + 1;
            if ($urandom_range(7) == 0) wait_drained();
        end
    endtask

    initial
    begin
        restart_message();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_random(50);
        send_idle = 82;
        test_random(40);
        send_idle = 0;
        recv_stall = 82;
        test_random(40);
        send_idle = 33;
        recv_stall = 33;
        test_random(40);
        wait_drained();
        repeat (200) @(posedge clk);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

    initial
    begin
        #20ms;
        $display("testbench: errors");
        $finish;
    end
endmodule

[sha256_message_digest.f]
sv/sha_pkg.sv
sv/sha_if.sv
sv/sha_front.sv
sv/sha_back.sv
sv/sha256_message_digest.sv
sv/sha_checker.sv
verif/testbench.sv
